FILE: design/jrsi_pkg.sv
// Shared types and constants for the JPEG reserved-segment inserter.
`timescale 1ns / 1ps
`default_nettype none
package jrsi_pkg;

    localparam int RSV_W = 23;   // reserved size and bytes left
    localparam int LEN_W = 16;   // segment length field
    localparam int POS_W = 17;   // byte position inside a segment

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_APP11  = 8'hEB;
    localparam logic [7:0] SIG_0       = 8'h4A;
    localparam logic [7:0] SIG_1       = 8'h50;
    localparam logic [7:0] SIG_2       = 8'h02;
    localparam logic [7:0] SIG_3       = 8'h11;
    localparam logic [7:0] HINT_0      = 8'h63;
    localparam logic [7:0] HINT_1      = 8'h32;
    localparam logic [7:0] HINT_2      = 8'h70;
    localparam logic [7:0] HINT_3      = 8'h61;

    localparam logic [RSV_W-1:0] MIN_SEG     = 23'd10;
    localparam logic [RSV_W-1:0] MIN_RESERVE = 23'd8;

    localparam logic CMD_IMAGE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MARK  = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_REFUSED   = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_D8     = 3'd1,
        PH_INSERT = 3'd2,
        PH_PASS   = 3'd3,
        PH_DROP   = 3'd4
    } t_phase;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [2:0] status;
        logic       insert_pending;
    } t_out_item;

endpackage
`default_nettype wire

FILE: design/jpeg_reserved_segment_inserter.sv
// Result beats are written into a registered result queue when their input beat is accepted.
// One input beat per cycle while the queue has room; a D8 beat with a valid size yields two result beats.
// A four-entry result queue absorbs the pair.
// Reset: synchronous, active low; clears phase, counters, queue and the size reg.
// The config write port is always ready.
`timescale 1ns / 1ps
`default_nettype none
module jpeg_reserved_segment_inserter
    import jrsi_pkg::*;
#(
    parameter int MAX_RESERVE = 4194304,
    parameter int MAX_SEGMENT = 65535
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [RSV_W-1:0] i_cfg_data
);

    localparam logic [RSV_W-1:0] L_MAX_SEG  = RSV_W'(MAX_SEGMENT);
    localparam logic [RSV_W-1:0] L_MAX_NEAR = RSV_W'(MAX_SEGMENT) + MIN_SEG;
    localparam logic [RSV_W-1:0] L_MAX_RSV  = RSV_W'(MAX_RESERVE);

    t_phase           r_phase, n_phase;
    logic [RSV_W-1:0] r_rsv_size;
    logic [RSV_W-1:0] r_left, n_left;
    logic [LEN_W-1:0] r_seg_len, n_seg_len;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_seg_num, n_seg_num;
    logic             r_ended, n_ended;

    t_out_item        r_fifo [4];
    logic [1:0]       r_wr_ptr, r_rd_ptr;
    logic [2:0]       r_count;

    logic             accept, pop;
    logic [1:0]       push_cnt;
    t_out_item        res0, res1;

    // next segment split
    logic             rem_big, rem_near;
    logic [LEN_W-1:0] seg_new, len_use;
    logic [RSV_W-1:0] left_new, rem_minus10, rem_minus_max;
    logic [7:0]       num_use, seg_byte;
    logic [POS_W-1:0] pos_inc;
    logic             seg_end;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_count <= 3'd2);
    assign o_out_valid = (r_count != 3'd0);
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign accept      = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    assign rem_big       = r_left > L_MAX_SEG;
    assign rem_near      = r_left < L_MAX_NEAR;
    assign rem_minus10   = r_left - MIN_SEG;
    assign rem_minus_max = r_left - L_MAX_SEG;

    always_comb begin
        if (!rem_big) begin
            seg_new  = r_left[LEN_W-1:0];
            left_new = '0;
        end else if (rem_near) begin
            seg_new  = rem_minus10[LEN_W-1:0];
            left_new = MIN_SEG;
        end else begin
            seg_new  = L_MAX_SEG[LEN_W-1:0];
            left_new = rem_minus_max;
        end
    end

    assign len_use = (r_pos == '0) ? seg_new : r_seg_len;
    assign num_use = (r_pos == '0) ? r_seg_num + 8'd1 : r_seg_num;
    assign pos_inc = r_pos + POS_W'(1);
    // a segment is at least ten long, so it never ends on its first byte
    assign seg_end = (r_pos != '0) && (pos_inc >= ({1'b0, r_seg_len} + POS_W'(2)));

    always_comb begin
        if (r_pos >= POS_W'(16)) begin
            seg_byte = 8'h00;
        end else begin
            case (r_pos[3:0])
                4'd0:    seg_byte = MARK_PREFIX;
                4'd1:    seg_byte = MARK_APP11;
                4'd2:    seg_byte = len_use[15:8];
                4'd3:    seg_byte = len_use[7:0];
                4'd4:    seg_byte = SIG_0;
                4'd5:    seg_byte = SIG_1;
                4'd6:    seg_byte = SIG_2;
                4'd7:    seg_byte = SIG_3;
                4'd11:   seg_byte = num_use;
                4'd12:   seg_byte = HINT_0;
                4'd13:   seg_byte = HINT_1;
                4'd14:   seg_byte = HINT_2;
                4'd15:   seg_byte = HINT_3;
                default: seg_byte = 8'h00;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_seg_len = r_seg_len;
        n_pos     = r_pos;
        n_seg_num = r_seg_num;
        n_ended   = r_ended;
        push_cnt  = 2'd0;
        res0      = '0;
        res1      = '0;
        if (accept) begin
            unique case (r_phase)
                PH_INSERT: begin
                    push_cnt = 2'd1;
                    if (i_in_data.cmd == CMD_IMAGE) begin
                        res0 = '{8'h00, 1'b0, ST_REFUSED, 1'b1};
                    end else begin
                        if (r_pos == '0) begin
                            n_seg_len = seg_new;
                            n_left    = left_new;
                            n_seg_num = num_use;
                        end
                        n_pos = pos_inc;
                        res0  = '{seg_byte, 1'b0, ST_OK, 1'b1};
                        if (seg_end) begin
                            n_pos = '0;
                            if (r_left == '0) begin
                                n_phase = r_ended ? PH_IDLE : PH_PASS;
                                res0    = '{seg_byte, r_ended, ST_OK, 1'b0};
                            end
                        end
                    end
                end
                PH_PASS: begin
                    push_cnt = 2'd1;
                    if (i_in_data.cmd == CMD_TICK) begin
                        res0 = '{8'h00, 1'b0, ST_REFUSED, 1'b0};
                    end else begin
                        res0 = '{i_in_data.in_byte, i_in_data.in_last, ST_OK, 1'b0};
                        if (i_in_data.in_last) n_phase = PH_IDLE;
                    end
                end
                PH_DROP: begin
                    if (i_in_data.cmd == CMD_IMAGE && i_in_data.in_last) n_phase = PH_IDLE;
                end
                PH_D8: begin
                    push_cnt = 2'd1;
                    if (i_in_data.cmd == CMD_TICK) begin
                        res0 = '{8'h00, 1'b0, ST_REFUSED, 1'b0};
                    end else if (i_in_data.in_byte != MARK_SOI) begin
                        res0    = '{8'h00, 1'b1, ST_BAD_MARK, 1'b0};
                        n_phase = i_in_data.in_last ? PH_IDLE : PH_DROP;
                    end else if (r_rsv_size < MIN_RESERVE || r_rsv_size > L_MAX_RSV) begin
                        res0    = '{8'h00, 1'b1, ST_BAD_SIZE, 1'b0};
                        n_phase = i_in_data.in_last ? PH_IDLE : PH_DROP;
                    end else begin
                        push_cnt  = 2'd2;
                        n_left    = r_rsv_size + RSV_W'(2);
                        n_seg_len = '0;
                        n_pos     = '0;
                        n_seg_num = '0;
                        n_ended   = i_in_data.in_last;
                        n_phase   = PH_INSERT;
                        res0      = '{MARK_PREFIX, 1'b0, ST_OK, 1'b1};
                        res1      = '{MARK_SOI, 1'b0, ST_OK, 1'b1};
                    end
                end
                default: begin
                    // idle, and any unused phase code
                    if (i_in_data.cmd == CMD_TICK) begin
                        push_cnt = 2'd1;
                        res0     = '{8'h00, 1'b0, ST_REFUSED, 1'b0};
                    end else if (i_in_data.in_last) begin
                        push_cnt = 2'd1;
                        res0     = '{8'h00, 1'b1, ST_SHORT, 1'b0};
                        n_phase  = PH_IDLE;
                    end else if (i_in_data.in_byte != MARK_PREFIX) begin
                        push_cnt = 2'd1;
                        res0     = '{8'h00, 1'b1, ST_BAD_MARK, 1'b0};
                        n_phase  = PH_DROP;
                    end else begin
                        // hold the FF until the D8 arrives
                        n_phase = PH_D8;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_rsv_size <= '0;
            r_left     <= '0;
            r_seg_len  <= '0;
            r_pos      <= '0;
            r_seg_num  <= '0;
            r_ended    <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_seg_len <= n_seg_len;
            r_pos     <= n_pos;
            r_seg_num <= n_seg_num;
            r_ended   <= n_ended;
            if (i_cfg_valid) r_rsv_size <= i_cfg_data;
            r_wr_ptr <= r_wr_ptr + push_cnt;
            if (pop) r_rd_ptr <= r_rd_ptr + 2'd1;
            r_count <= r_count + {1'b0, push_cnt} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) r_fifo[r_wr_ptr] <= res0;
        if (push_cnt == 2'd2) r_fifo[r_wr_ptr + 2'd1] <= res1;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == $past(r_count) + {1'b0, $past(push_cnt)}
                                      - {2'b00, $past(pop)})
        else $error("queue count does not follow push and pop");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_INSERT && r_pos != '0) |-> r_pos <= ({1'b0, r_seg_len} + POS_W'(1)))
        else $error("segment position past segment end");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> o_out_data.out_byte == 8'h00)
        else $error("error beat carries a nonzero byte");

    a_pair_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_cnt == 2'd2) |=> r_phase == PH_INSERT)
        else $error("marker pair pushed without entering insertion");
`endif

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the JPEG reserved-segment inserter: directed and random images.
`timescale 1ns / 1ps
`default_nettype none
module testbench
    import jrsi_pkg::*;
();

    localparam int RESERVE_CAP = 4194304;
    localparam int SEGMENT_CAP = 65535;
    localparam int TAIL_IMAGES = 3;
    localparam int BEAT_TARGET = 1750;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 8;
    localparam int TAIL_CYCLES = 16;

    // Tracks the inserter state and holds the result beats it must produce.
    class inserter_scoreboard;
        logic [RSV_W-1:0] reserve;
        t_phase           phase;
        logic [RSV_W-1:0] left;
        logic [LEN_W-1:0] seg_len;
        logic [POS_W-1:0] pos;
        logic [7:0]       seg_num;
        logic             ended_at_soi;
        t_out_item        expected_beats[$];
        int               errors;
        int               checked;

        function new();
            reserve      = '0;
            phase        = PH_IDLE;
            left         = '0;
            seg_len      = '0;
            pos          = '0;
            seg_num      = '0;
            ended_at_soi = 1'b0;
            errors       = 0;
            checked      = 0;
        endfunction

        function void push_beat(logic [7:0] b, logic l, logic [2:0] st, logic p);
            t_out_item e;
            e.out_byte       = b;
            e.out_last       = l;
            e.status         = st;
            e.insert_pending = p;
            expected_beats.push_back(e);
        endfunction

        function void abort_image(logic [2:0] st, logic l);
            push_beat(8'h00, 1'b1, st, 1'b0);
            phase = l ? PH_IDLE : PH_DROP;
        endfunction

        function logic [7:0] segment_byte(int p);
            case (p)
                0:  return MARK_PREFIX;
                1:  return MARK_APP11;
                2:  return seg_len[15:8];
                3:  return seg_len[7:0];
                4:  return SIG_0;
                5:  return SIG_1;
                6:  return SIG_2;
                7:  return SIG_3;
                11: return seg_num;
                12: return HINT_0;
                13: return HINT_1;
                14: return HINT_2;
                15: return HINT_3;
                default: return 8'h00;
            endcase
        endfunction

        function void insert_beat();
            int rem;
            int seg;
            int rest;
            logic [7:0] b;
            if (pos == '0) begin
                // open a segment; leave at least a minimal segment behind it
                rem  = int'(left);
                seg  = (rem < SEGMENT_CAP) ? rem : SEGMENT_CAP;
                rest = rem - seg;
                if (rest > 0 && rest < int'(MIN_SEG)) seg -= int'(MIN_SEG) - rest;
                seg_len = LEN_W'(seg);
                left    = RSV_W'(rem - seg);
                seg_num = seg_num + 8'd1;
            end
            b   = segment_byte(int'(pos));
            pos = pos + 1'b1;
            if (int'(pos) >= int'(seg_len) + 2) begin
                pos = '0;
                if (left == '0) begin
                    phase = ended_at_soi ? PH_IDLE : PH_PASS;
                    push_beat(b, ended_at_soi, ST_OK, 1'b0);
                    return;
                end
            end
            push_beat(b, 1'b0, ST_OK, 1'b1);
        endfunction

        function void note_beat(t_in_item it);
            case (phase)
                PH_INSERT: begin
                    if (it.cmd == CMD_IMAGE) push_beat(8'h00, 1'b0, ST_REFUSED, 1'b1);
                    else insert_beat();
                end
                PH_PASS: begin
                    if (it.cmd == CMD_TICK) begin
                        push_beat(8'h00, 1'b0, ST_REFUSED, 1'b0);
                    end else begin
                        push_beat(it.in_byte, it.in_last, ST_OK, 1'b0);
                        if (it.in_last) phase = PH_IDLE;
                    end
                end
                PH_DROP: begin
                    if (it.cmd == CMD_IMAGE && it.in_last) phase = PH_IDLE;
                end
                PH_D8: begin
                    if (it.cmd == CMD_TICK) begin
                        push_beat(8'h00, 1'b0, ST_REFUSED, 1'b0);
                    end else if (it.in_byte != MARK_SOI) begin
                        abort_image(ST_BAD_MARK, it.in_last);
                    end else if (reserve < MIN_RESERVE || int'(reserve) > RESERVE_CAP) begin
                        abort_image(ST_BAD_SIZE, it.in_last);
                    end else begin
                        left         = reserve + RSV_W'(2);
                        seg_len      = '0;
                        pos          = '0;
                        seg_num      = '0;
                        ended_at_soi = it.in_last;
                        phase        = PH_INSERT;
                        push_beat(MARK_PREFIX, 1'b0, ST_OK, 1'b1);
                        push_beat(MARK_SOI, 1'b0, ST_OK, 1'b1);
                    end
                end
                default: begin
                    if (it.cmd == CMD_TICK) begin
                        push_beat(8'h00, 1'b0, ST_REFUSED, 1'b0);
                    end else if (it.in_last) begin
                        abort_image(ST_SHORT, 1'b1);
                    end else if (it.in_byte != MARK_PREFIX) begin
                        abort_image(ST_BAD_MARK, 1'b0);
                    end else begin
                        phase = PH_D8;
                    end
                end
            endcase
        endfunction

        function void check_beat(t_out_item got);
            t_out_item want;
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat: byte %h last %b status %0d pending %b",
                       got.out_byte, got.out_last, got.status, got.insert_pending);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            checked++;
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.out_last !== want.out_last) begin
                $error("out_last: expected %b, got %b", want.out_last, got.out_last);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.insert_pending !== want.insert_pending) begin
                $error("insert_pending: expected %b, got %b",
                       want.insert_pending, got.insert_pending);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in_item         in_data;
    logic             out_valid;
    logic             out_ready;
    t_out_item        out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [RSV_W-1:0] cfg_data;

    inserter_scoreboard sb;
    bit calm;
    bit long_hold_req;
    int in_beats;
    int images;
    int quiet_cycles;

    jpeg_reserved_segment_inserter #(
        .MAX_RESERVE(RESERVE_CAP),
        .MAX_SEGMENT(SEGMENT_CAP)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_beat(out_data);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : receiver
        int stall;
        stall = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end else if (stall == 0 && !calm && $urandom_range(0, 11) == 0) begin
                stall = $urandom_range(1, 17);
            end
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(logic c, logic [7:0] b, logic l);
        t_in_item it;
        it.cmd     = c;
        it.in_byte = b;
        it.in_last = l;
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        if (sb.phase != PH_DROP) in_beats++;
        sb.note_beat(it);
    endtask

    task automatic send_tick();
        send_beat(CMD_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_beats.size() != 0);
        // let a held or dropped beat settle before touching the register
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reserve(logic [RSV_W-1:0] v);
        pause_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.reserve = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [RSV_W-1:0] pick_reserve();
        case ($urandom_range(0, 5))
            0:       return MIN_RESERVE;
            1:       return RSV_W'($urandom_range(9, 400));
            default: return RSV_W'($urandom_range(9, 48));
        endcase
    endfunction

    function automatic logic [RSV_W-1:0] pick_bad_reserve();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return MIN_RESERVE - 1'b1;
            2:       return RSV_W'(RESERVE_CAP + 1);
            3:       return '1;
            4:       return RSV_W'($urandom_range(0, 7));
            default: return RSV_W'($urandom_range(RESERVE_CAP + 1, 8388607));
        endcase
    endfunction

    task automatic insert_all(bit noisy);
        while (sb.phase == PH_INSERT) begin
            if (noisy && $urandom_range(0, 24) == 0)
                send_beat(CMD_IMAGE, 8'($urandom), 1'($urandom));
            else
                send_tick();
        end
    endtask

    // Bring the block back to idle from whatever phase it was left in.
    task automatic finish_open_image();
        while (sb.phase != PH_IDLE) begin
            if (sb.phase == PH_INSERT) send_tick();
            else send_beat(CMD_IMAGE, 8'($urandom), 1'b1);
        end
    endtask

    task automatic send_dropped_noise();
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 1)) send_tick();
            else send_beat(CMD_IMAGE, 8'($urandom), 1'b0);
        end
    endtask

    task automatic good_image();
        int body;
        send_beat(CMD_IMAGE, MARK_PREFIX, 1'b0);
        send_beat(CMD_IMAGE, MARK_SOI, $urandom_range(0, 9) == 0);
        insert_all(1'b1);
        if (sb.phase == PH_PASS) begin
            body = $urandom_range(1, 12);
            for (int i = 1; i <= body; i++) begin
                if ($urandom_range(0, 19) == 0) send_tick();
                send_beat(CMD_IMAGE, 8'($urandom), i == body);
            end
        end
        finish_open_image();
    endtask

    task automatic broken_image();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: begin
                do b = 8'($urandom); while (b == MARK_PREFIX);
                send_beat(CMD_IMAGE, b, 1'b0);
                send_dropped_noise();
            end
            1: begin
                b = $urandom_range(0, 1) ? MARK_PREFIX : 8'($urandom);
                send_beat(CMD_IMAGE, b, 1'b1);
            end
            2: begin
                send_beat(CMD_IMAGE, MARK_PREFIX, 1'b0);
                do b = 8'($urandom); while (b == MARK_SOI);
                send_beat(CMD_IMAGE, b, 1'($urandom));
                send_dropped_noise();
            end
            3: begin
                send_tick();
                send_beat(CMD_IMAGE, MARK_PREFIX, 1'b0);
                send_tick();
                send_beat(CMD_IMAGE, MARK_SOI, 1'b0);
            end
            4: begin
                repeat ($urandom_range(1, 6))
                    send_beat(1'($urandom), 8'($urandom), 1'($urandom));
            end
            default: begin
                write_reserve(pick_bad_reserve());
                send_beat(CMD_IMAGE, MARK_PREFIX, 1'b0);
                send_beat(CMD_IMAGE, MARK_SOI, 1'($urandom));
                send_dropped_noise();
                finish_open_image();
                write_reserve(pick_reserve());
            end
        endcase
        finish_open_image();
    endtask

    initial begin : stimulus
        sb = new();
        calm = 1'b0;
        long_hold_req = 1'b0;
        in_beats = 0;
        images = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick();                                  // refused while idle
        send_beat(CMD_IMAGE, 8'h00, 1'b1);            // image ends on its first byte
        send_beat(CMD_IMAGE, MARK_PREFIX, 1'b1);
        send_beat(CMD_IMAGE, 8'h12, 1'b0);            // bad first marker, then drop
        send_tick();
        send_beat(CMD_IMAGE, MARK_PREFIX, 1'b1);
        send_beat(CMD_IMAGE, MARK_PREFIX, 1'b0);
        send_beat(CMD_IMAGE, MARK_SOI, 1'b1);         // size still zero: bad size
        write_reserve(RSV_W'(RESERVE_CAP));
        send_beat(CMD_IMAGE, MARK_PREFIX, 1'b0);
        send_beat(CMD_IMAGE, 8'h00, 1'b0);            // bad second marker
        send_beat(CMD_IMAGE, MARK_SOI, 1'b1);
        write_reserve(MIN_RESERVE);
        send_beat(CMD_IMAGE, MARK_PREFIX, 1'b0);
        send_beat(CMD_IMAGE, MARK_SOI, 1'b1);         // image holds only the marker
        send_tick();
        send_beat(CMD_IMAGE, 8'hA5, 1'b0);            // refused during insertion
        insert_all(1'b0);
        write_reserve(RSV_W'(12));                    // long enough for all hint bytes
        send_beat(CMD_IMAGE, MARK_PREFIX, 1'b0);
        send_tick();                                  // refused while awaiting D8
        send_beat(CMD_IMAGE, MARK_SOI, 1'b0);
        insert_all(1'b0);
        send_tick();                                  // refused while passing
        send_beat(CMD_IMAGE, 8'h00, 1'b0);
        send_beat(CMD_IMAGE, 8'hFF, 1'b1);

        while (in_beats < BEAT_TARGET) begin
            images++;
            if (images % 6 == 0) write_reserve(pick_reserve());
            if (images == 20) pause_until_drained();
            // stall the output long enough to back up into the input
            if (images == 10) long_hold_req = 1'b1;
            if (images == 10 || $urandom_range(0, 9) < 7) good_image();
            else broken_image();
        end

        // quiet tail: no idling on either side
        calm = 1'b1;
        write_reserve(pick_reserve());
        repeat (TAIL_IMAGES) begin
            good_image();
            images++;
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("drove %0d input beats over %0d images, checked %0d result beats",
                 in_beats, images, sb.checked);
        $display("sizes from zero to the 23-bit limit, errors, refusals and a long stall");
        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
design/jrsi_pkg.sv
design/jpeg_reserved_segment_inserter.sv
bench/testbench.sv
